FILE: hw/rtl/ppa_pkg.sv
// Shared types and codes of the pairwise preference accumulator.
`timescale 1ns / 1ps
package ppa_pkg;

    // Input item kinds.
    localparam logic [1:0] KIND_UPDATE = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  index_a;
        logic [7:0]  index_b;
        logic [15:0] dist_left;
        logic [15:0] dist_right;
    } t_item;

    typedef struct packed {
        logic [31:0] score;
        logic [15:0] closest_left;
        logic [15:0] closest_right;
        logic [7:0]  left_parent;
        logic [7:0]  right_parent;
        logic        left_found;
        logic        right_found;
    } t_result;

    // Operations handed from the front part to the back part.
    typedef enum logic [1:0] {
        OP_UPDATE,
        OP_READ,
        OP_READ_RESET,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [7:0]  index_a;
        logic [7:0]  index_b;
        logic [15:0] dist_left;
        logic [15:0] dist_right;
        logic [15:0] add;
    } t_cmd;

    // One table entry as held in memory.
    typedef struct packed {
        logic [31:0] score;
        logic [15:0] closest_left;
        logic [15:0] closest_right;
        logic [7:0]  left_parent;
        logic [7:0]  right_parent;
        logic        left_found;
        logic        right_found;
    } t_entry;

endpackage

FILE: hw/rtl/pairwise_preference_accumulator_top.sv
// Top level of the pairwise preference accumulator.
`timescale 1ns / 1ps
// Usage:
//   Requests enter on a queue-style port: i_item is taken at a clock edge with
//   push high and full low. Kinds are pair update, entry read and entry clear;
//   reads alone produce a result. Results leave on a second queue-style port:
//   o_result holds the oldest result while empty is low and is taken at an
//   edge with pop high. Write the correction-mode bit through i_cfg_valid /
//   o_cfg_ready / i_cfg_data only while the block is idle.
// Flow:
//   The front part keeps full high from taking a request until it hands it to
//   the request queue; a request that changes nothing (equal or out-of-range
//   update indices, unused kind, out-of-range clear) is dropped in the idle state. In
//   correction mode an update first passes the root state, one square-root
//   digit of both distances per cycle. The back part serves one request at a
//   time: it reads both entries of an update, then writes a, then b on the
//   single write port; a read reads its entry, then pushes the result; a clear
//   resets the entry's valid bit on pop. A two-entry request queue sits between the parts.
// Reset: synchronous, active low; all valid bits clear at once, so every
//   entry reads as its cleared value without a sweep of the memory.
// Stall: with the result queue full, reads hold in the back part, the request
//   queue fills, and full stays high until space frees up.
module pairwise_preference_accumulator_top
    import ppa_pkg::*;
#(
    parameter int MAX_SEQS  = 256,
    parameter int DIST_BITS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    push,
    input  t_item   i_item,
    output logic    full,
    output logic    empty,
    input  logic    pop,
    output t_result o_result,
    input  logic    i_cfg_valid,
    output logic    o_cfg_ready,
    input  logic    i_cfg_data
);
    logic    r_corr;
    logic    w_cmd_push, w_cmd_full, w_cmd_empty, w_cmd_pop;
    t_cmd    w_cmd_in, w_cmd_out;
    logic    w_res_push, w_res_full;
    t_result w_res;

    // Configuration is always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corr <= 1'b0;
        end else if (i_cfg_valid) begin
            r_corr <= i_cfg_data;
        end
    end

    ppa_front #(
        .MAX_SEQS (MAX_SEQS),
        .DIST_BITS(DIST_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_corr    (r_corr),
        .i_push    (push),
        .i_item    (i_item),
        .o_full    (full),
        .o_cmd_push(w_cmd_push),
        .o_cmd     (w_cmd_in),
        .i_cmd_full(w_cmd_full)
    );

    ppa_fifo #(
        .WIDTH($bits(t_cmd))
    ) u_cmd_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_cmd_push),
        .i_data (w_cmd_in),
        .o_full (w_cmd_full),
        .i_pop  (w_cmd_pop),
        .o_data (w_cmd_out),
        .o_empty(w_cmd_empty)
    );

    ppa_back #(
        .MAX_SEQS (MAX_SEQS),
        .DIST_BITS(DIST_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_empty(w_cmd_empty),
        .i_cmd      (w_cmd_out),
        .o_cmd_pop  (w_cmd_pop),
        .o_res_push (w_res_push),
        .o_res      (w_res),
        .i_res_full (w_res_full)
    );

    // Result queue parts the back part from a stalled receiver.
    ppa_fifo #(
        .WIDTH($bits(t_result))
    ) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_res_push),
        .i_data (w_res),
        .o_full (w_res_full),
        .i_pop  (pop),
        .o_data (o_result),
        .o_empty(empty)
    );
endmodule

FILE: hw/rtl/ppa_fifo.sv
// Two-entry queue for requests and results.
`timescale 1ns / 1ps
module ppa_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    logic [WIDTH-1:0] r_slot [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_slot[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wp] <= i_data;
        end
    end
endmodule

FILE: hw/rtl/ppa_front.sv
// Front part: accept, classify, take square roots in correction mode and form the score increment.
`timescale 1ns / 1ps
module ppa_front
    import ppa_pkg::*;
#(
    parameter int MAX_SEQS  = 256,
    parameter int DIST_BITS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_corr,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_cmd_push,
    output t_cmd  o_cmd,
    input  logic  i_cmd_full
);
    localparam int DB   = DIST_BITS;
    localparam int CW   = $clog2(DB + 1);
    localparam int SH_R = (DB >= 16) ? DB - 16 : 0;
    localparam int SH_L = (DB >= 16) ? 0 : 16 - DB;
    localparam logic [15:0] DMASK = (DB >= 16) ? 16'hFFFF : 16'((64'd1 << DB) - 64'd1);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_ROOT = 3'b010,
        F_SEND = 3'b100
    } t_fstate;

    t_fstate          r_state, n_state;
    t_op              r_op;
    logic [7:0]       r_a, r_b;
    logic [15:0]      r_dl, r_dr;
    logic [DB-1:0]    r_x, r_y;
    logic [2*DB-1:0]  r_rad_x, r_rad_y;
    logic [DB+1:0]    r_rem_x, r_rem_y;
    logic [CW-1:0]    r_cnt;

    logic             w_take;
    logic [15:0]      w_dl, w_dr;
    logic             w_a_in, w_b_in;
    logic [DB+3:0]    w_sx, w_sy, w_tx, w_ty;
    logic [DB-1:0]    w_diff;

    assign o_full = (r_state != F_IDLE);
    assign w_take = i_push && (r_state == F_IDLE);
    assign w_dl   = i_item.dist_left & DMASK;
    assign w_dr   = i_item.dist_right & DMASK;
    assign w_a_in = (32'(i_item.index_a) < 32'(MAX_SEQS));
    assign w_b_in = (32'(i_item.index_b) < 32'(MAX_SEQS));

    // One root digit per cycle for both distances.
    always_comb begin
        w_sx = {r_rem_x, r_rad_x[2*DB-1 -: 2]};
        w_sy = {r_rem_y, r_rad_y[2*DB-1 -: 2]};
        w_tx = {2'b00, r_x, 2'b01};
        w_ty = {2'b00, r_y, 2'b01};
    end

    assign w_diff = (r_x >= r_y) ? (r_x - r_y) : (r_y - r_x);

    always_comb begin
        o_cmd.op         = r_op;
        o_cmd.index_a    = r_a;
        o_cmd.index_b    = r_b;
        o_cmd.dist_left  = r_dl;
        o_cmd.dist_right = r_dr;
        o_cmd.add        = 16'(w_diff >> SH_R) << SH_L;
        o_cmd_push       = (r_state == F_SEND) && !i_cmd_full;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (w_take) begin
                    if (i_item.kind == KIND_UPDATE) begin
                        if (i_item.index_a != i_item.index_b && w_a_in && w_b_in) begin
                            n_state = i_corr ? F_ROOT : F_SEND;
                        end
                    end else if (i_item.kind == KIND_READ) begin
                        n_state = F_SEND;
                    end else if (i_item.kind == KIND_CLEAR) begin
                        if (w_a_in) begin
                            n_state = F_SEND;
                        end
                    end
                end
            end
            F_ROOT: begin
                if (r_cnt == CW'(DB - 1)) begin
                    n_state = F_SEND;
                end
            end
            F_SEND: begin
                if (!i_cmd_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_a     <= i_item.index_a;
            r_b     <= i_item.index_b;
            r_dl    <= w_dl;
            r_dr    <= w_dr;
            r_cnt   <= '0;
            r_rem_x <= '0;
            r_rem_y <= '0;
            r_rad_x <= {DB'(w_dl), DB'(0)};
            r_rad_y <= {DB'(w_dr), DB'(0)};
            if (i_corr) begin
                r_x <= '0;
                r_y <= '0;
            end else begin
                r_x <= DB'(w_dl);
                r_y <= DB'(w_dr);
            end
            if (i_item.kind == KIND_UPDATE) begin
                r_op <= OP_UPDATE;
            end else if (i_item.kind == KIND_CLEAR) begin
                r_op <= OP_CLEAR;
            end else if (w_a_in) begin
                r_op <= OP_READ;
            end else begin
                r_op <= OP_READ_RESET;
            end
        end else if (r_state == F_ROOT) begin
            r_cnt   <= r_cnt + CW'(1);
            r_rad_x <= r_rad_x << 2;
            r_rad_y <= r_rad_y << 2;
            if (w_sx >= w_tx) begin
                r_rem_x <= (DB + 2)'(w_sx - w_tx);
                r_x     <= {r_x[DB-2:0], 1'b1};
            end else begin
                r_rem_x <= (DB + 2)'(w_sx);
                r_x     <= {r_x[DB-2:0], 1'b0};
            end
            if (w_sy >= w_ty) begin
                r_rem_y <= (DB + 2)'(w_sy - w_ty);
                r_y     <= {r_y[DB-2:0], 1'b1};
            end else begin
                r_rem_y <= (DB + 2)'(w_sy);
                r_y     <= {r_y[DB-2:0], 1'b0};
            end
        end
    end
endmodule

FILE: hw/rtl/ppa_back.sv
// Back part: entry memory with valid bits, read-modify-write of pair updates, reads and clears.
`timescale 1ns / 1ps
module ppa_back
    import ppa_pkg::*;
#(
    parameter int MAX_SEQS  = 256,
    parameter int DIST_BITS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_empty,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    output logic    o_res_push,
    output t_result o_res,
    input  logic    i_res_full
);
    localparam int DEPTH = (MAX_SEQS < 256) ? MAX_SEQS : 256;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [15:0] RST_DIST =
        (DIST_BITS >= 16) ? 16'hFFFF : 16'((64'd1 << DIST_BITS) - 64'd1);
    localparam t_entry RST_ENTRY = '{score: 32'd0, closest_left: RST_DIST,
        closest_right: RST_DIST, left_parent: 8'd0, right_parent: 8'd0,
        left_found: 1'b0, right_found: 1'b0};

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_WRA  = 4'b0010,
        B_WRB  = 4'b0100,
        B_RES  = 4'b1000
    } t_bstate;

    t_bstate          r_state, n_state;
    t_cmd             r_cmd;
    t_entry           r_mem [DEPTH];
    t_entry           r_rd_a, r_rd_b;
    logic             r_va, r_vb;
    logic [DEPTH-1:0] r_valid;

    logic             w_rd_en;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    t_entry           w_wdata;
    t_entry           w_ea, w_eb;

    function automatic t_entry touch(t_entry e, logic [7:0] other, logic [15:0] add,
                                     logic [15:0] dl, logic [15:0] dr);
        t_entry      t;
        logic [32:0] s;
        t = e;
        s = {1'b0, e.score} + 33'(add);
        t.score = s[32] ? 32'hFFFF_FFFF : s[31:0];
        if (!e.left_found || dl < e.closest_left) begin
            t.closest_left = dl;
            t.left_parent  = other;
            t.left_found   = 1'b1;
        end
        if (!e.right_found || dr < e.closest_right) begin
            t.closest_right = dr;
            t.right_parent  = other;
            t.right_found   = 1'b1;
        end
        return t;
    endfunction

    assign w_ea = r_va ? r_rd_a : RST_ENTRY;
    assign w_eb = r_vb ? r_rd_b : RST_ENTRY;

    always_comb begin
        n_state   = r_state;
        o_cmd_pop = 1'b0;
        w_rd_en   = 1'b0;
        w_we      = 1'b0;
        w_waddr   = r_cmd.index_a[AW-1:0];
        w_wdata   = touch(w_ea, r_cmd.index_b, r_cmd.add, r_cmd.dist_left,
                          r_cmd.dist_right);
        case (r_state)
            B_IDLE: begin
                if (!i_cmd_empty) begin
                    case (i_cmd.op)
                        OP_UPDATE: begin
                            o_cmd_pop = 1'b1;
                            w_rd_en   = 1'b1;
                            n_state   = B_WRA;
                        end
                        OP_READ, OP_READ_RESET: begin
                            if (!i_res_full) begin
                                o_cmd_pop = 1'b1;
                                w_rd_en   = 1'b1;
                                n_state   = B_RES;
                            end
                        end
                        OP_CLEAR: o_cmd_pop = 1'b1;
                        default: o_cmd_pop = 1'b1;
                    endcase
                end
            end
            B_WRA: begin
                w_we    = 1'b1;
                n_state = B_WRB;
            end
            B_WRB: begin
                w_we    = 1'b1;
                w_waddr = r_cmd.index_b[AW-1:0];
                w_wdata = touch(w_eb, r_cmd.index_a, r_cmd.add, r_cmd.dist_left,
                                r_cmd.dist_right);
                n_state = B_IDLE;
            end
            B_RES: n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_res_push          = (r_state == B_RES);
        o_res.score         = w_ea.score;
        o_res.closest_left  = w_ea.closest_left;
        o_res.closest_right = w_ea.closest_right;
        o_res.left_parent   = w_ea.left_parent;
        o_res.right_parent  = w_ea.right_parent;
        o_res.left_found    = w_ea.left_found;
        o_res.right_found   = w_ea.right_found;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            if (w_we) begin
                r_valid[w_waddr] <= 1'b1;
            end
            if (o_cmd_pop && i_cmd.op == OP_CLEAR) begin
                r_valid[i_cmd.index_a[AW-1:0]] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (w_rd_en) begin
            r_rd_a <= r_mem[i_cmd.index_a[AW-1:0]];
            r_rd_b <= r_mem[i_cmd.index_b[AW-1:0]];
            r_va   <= r_valid[i_cmd.index_a[AW-1:0]] && (i_cmd.op != OP_READ_RESET);
            r_vb   <= r_valid[i_cmd.index_b[AW-1:0]];
        end
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end
endmodule

FILE: tb/tb_pairwise_preference_accumulator_top.sv
// Testbench of the pairwise preference accumulator: directed and random requests checked against a predictor.
`timescale 1ns / 1ps
module tb_pairwise_preference_accumulator_top;
    import ppa_pkg::*;

    // Predicted entry table plus the queue of expected read results.
    class pref_table_scoreboard;
        bit [31:0] score[256];
        bit [15:0] near_left[256];
        bit [15:0] near_right[256];
        bit [7:0]  par_left[256];
        bit [7:0]  par_right[256];
        bit        got_left[256];
        bit        got_right[256];
        bit        sqrt_mode;
        t_result   pending_reads[$];
        int        mismatches;

        function void clear_entry(int k);
            score[k] = '0;
            near_left[k] = 16'hFFFF;
            near_right[k] = 16'hFFFF;
            par_left[k] = '0;
            par_right[k] = '0;
            got_left[k] = 1'b0;
            got_right[k] = 1'b0;
        endfunction

        function void reset_all();
            sqrt_mode = 1'b0;
            mismatches = 0;
            for (int k = 0; k < 256; k++) clear_entry(k);
        endfunction

        // Floor square root of a 32-bit value, digit by digit.
        function bit [15:0] isqrt(bit [31:0] v);
            bit [31:0] root;
            bit [31:0] bitv;
            root = '0;
            bitv = 32'h4000_0000;
            while (bitv > v) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (v >= root + bitv) begin
                    v = v - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            return root[15:0];
        endfunction

        function void touch(int k, bit [7:0] other, bit [15:0] add, bit [15:0] dl,
                            bit [15:0] dr);
            bit [32:0] sum;
            sum = {1'b0, score[k]} + {17'd0, add};
            score[k] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            if (!got_left[k] || dl < near_left[k]) begin
                near_left[k] = dl;
                par_left[k] = other;
                got_left[k] = 1'b1;
            end
            if (!got_right[k] || dr < near_right[k]) begin
                near_right[k] = dr;
                par_right[k] = other;
                got_right[k] = 1'b1;
            end
        endfunction

        function void note_request(t_item it);
            bit [15:0] x;
            bit [15:0] y;
            bit [15:0] add;
            t_result r;
            case (it.kind)
                KIND_UPDATE: begin
                    if (it.index_a != it.index_b) begin
                        x = sqrt_mode ? isqrt({it.dist_left, 16'h0}) : it.dist_left;
                        y = sqrt_mode ? isqrt({it.dist_right, 16'h0}) : it.dist_right;
                        add = (x >= y) ? x - y : y - x;
                        touch(int'(it.index_a), it.index_b, add, it.dist_left,
                              it.dist_right);
                        touch(int'(it.index_b), it.index_a, add, it.dist_left,
                              it.dist_right);
                    end
                end
                KIND_READ: begin
                    r.score = score[it.index_a];
                    r.closest_left = near_left[it.index_a];
                    r.closest_right = near_right[it.index_a];
                    r.left_parent = par_left[it.index_a];
                    r.right_parent = par_right[it.index_a];
                    r.left_found = got_left[it.index_a];
                    r.right_found = got_right[it.index_a];
                    pending_reads = {pending_reads, r};
                end
                KIND_CLEAR: clear_entry(int'(it.index_a));
                default: ;
            endcase
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_reads.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending_reads.pop_front();
            if (got.score !== want.score || got.closest_left !== want.closest_left ||
                got.closest_right !== want.closest_right ||
                got.left_parent !== want.left_parent ||
                got.right_parent !== want.right_parent ||
                got.left_found !== want.left_found ||
                got.right_found !== want.right_found) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("read mismatch: expected %h actual %h", want, got);
            end
        endfunction
    endclass

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    push = 1'b0;
    t_item   i_item = '0;
    logic    full;
    logic    empty;
    logic    pop = 1'b0;
    t_result o_result;
    logic    i_cfg_valid = 1'b0;
    logic    o_cfg_ready;
    logic    i_cfg_data = 1'b0;

    pref_table_scoreboard sb;
    bit hold_off = 1'b0;
    bit stim_done = 1'b0;

    always #1 i_clk = ~i_clk;

    pairwise_preference_accumulator_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .i_item(i_item), .full(full),
        .empty(empty), .pop(pop), .o_result(o_result), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // Hold one request until it is accepted; pass the prediction on acceptance.
    task automatic send_request(t_item it);
        push <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        sb.note_request(it);
        @(negedge i_clk);
    endtask

    task automatic idle_sender(int n);
        push <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // Drain all pending reads, let updates settle, then write the mode bit.
    task automatic write_mode(bit m);
        idle_sender(1);
        while (sb.pending_reads.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.sqrt_mode = m;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_item make_item(bit [1:0] k, bit [7:0] a, bit [7:0] b,
                                        bit [15:0] dl, bit [15:0] dr);
        t_item it;
        it.kind = k;
        it.index_a = a;
        it.index_b = b;
        it.dist_left = dl;
        it.dist_right = dr;
        return it;
    endfunction

    // Most updates land on a few hot entries so reads hit filled state.
    function automatic t_item random_item();
        bit [1:0] k;
        bit [7:0] a;
        bit [7:0] b;
        int sel;
        sel = int'($urandom_range(0, 99));
        if (sel < 55) k = KIND_UPDATE;
        else if (sel < 85) k = KIND_READ;
        else if (sel < 95) k = KIND_CLEAR;
        else k = 2'd3;
        if ($urandom_range(0, 3) != 0) begin
            a = 8'($urandom_range(0, 7));
            b = 8'($urandom_range(0, 7));
        end else begin
            a = 8'($urandom);
            b = 8'($urandom);
        end
        return make_item(k, a, b, 16'($urandom), 16'($urandom));
    endfunction

    task automatic random_phase(int n);
        int burst;
        while (n > 0) begin
            burst = int'($urandom_range(1, 12));
            while (burst > 0 && n > 0) begin
                send_request(random_item());
                burst--;
                n--;
            end
            if ($urandom_range(0, 2) != 0) idle_sender(int'($urandom_range(1, 6)));
        end
    endtask

    // Result side: random stalls, long hold-off when asked.
    always @(negedge i_clk) begin
        if (hold_off) pop <= 1'b0;
        else pop <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) sb.check_result(o_result);
    end

    // Hold the receiver off for a long stretch early in the random part.
    initial begin
        wait (stim_done === 1'b0 && i_rst_n === 1'b1);
        repeat (400) @(negedge i_clk);
        hold_off = 1'b1;
        repeat (300) @(negedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        sb = new();
        sb.reset_all();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reads of reset entries, extremes, equal indices, ties, clears.
        send_request(make_item(KIND_READ, 8'd0, 8'd0, 16'h0, 16'h0));
        send_request(make_item(KIND_READ, 8'd255, 8'd0, 16'h0, 16'h0));
        send_request(make_item(KIND_UPDATE, 8'd0, 8'd255, 16'hFFFF, 16'h0000));
        send_request(make_item(KIND_UPDATE, 8'd255, 8'd1, 16'h0000, 16'hFFFF));
        send_request(make_item(KIND_UPDATE, 8'd1, 8'd2, 16'h0000, 16'hFFFF));
        send_request(make_item(KIND_UPDATE, 8'd3, 8'd3, 16'h1234, 16'h0001));
        send_request(make_item(KIND_UPDATE, 8'd0, 8'd4, 16'hFFFF, 16'h0000));
        send_request(make_item(KIND_UPDATE, 8'd0, 8'd5, 16'hFFFF, 16'h0000));
        send_request(make_item(2'd3, 8'd0, 8'd1, 16'hAAAA, 16'h5555));
        for (int i = 0; i < 6; i++)
            send_request(make_item(KIND_READ, 8'(i), 8'd0, 16'h0, 16'h0));
        send_request(make_item(KIND_READ, 8'd255, 8'd0, 16'h0, 16'h0));
        send_request(make_item(KIND_CLEAR, 8'd0, 8'd0, 16'h0, 16'h0));
        send_request(make_item(KIND_READ, 8'd0, 8'd0, 16'h0, 16'h0));

        write_mode(1'b1);
        send_request(make_item(KIND_UPDATE, 8'd6, 8'd7, 16'hFFFF, 16'h0001));
        send_request(make_item(KIND_UPDATE, 8'd6, 8'd7, 16'h0000, 16'h0000));
        send_request(make_item(KIND_READ, 8'd6, 8'd0, 16'h0, 16'h0));
        send_request(make_item(KIND_READ, 8'd7, 8'd0, 16'h0, 16'h0));
        random_phase(150);

        write_mode(1'b0);
        random_phase(150);
        write_mode(1'b1);
        random_phase(100);
        write_mode(1'b0);
        random_phase(50);

        stim_done = 1'b1;
        idle_sender(1);
        while (sb.pending_reads.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (sb.mismatches == 0) $display("tb_pairwise_preference_accumulator_top passed");
        else $display("tb_pairwise_preference_accumulator_top failed");
        $finish;
    end

    // End the run on a hang.
    initial begin
        #200000;
        $display("tb_pairwise_preference_accumulator_top failed");
        $finish;
    end
endmodule

FILE: files.f
hw/rtl/ppa_pkg.sv
hw/rtl/ppa_fifo.sv
hw/rtl/ppa_front.sv
hw/rtl/ppa_back.sv
hw/rtl/pairwise_preference_accumulator_top.sv
tb/tb_pairwise_preference_accumulator_top.sv
